/* hw/rtl/cst_pkg.sv */
package cst_pkg;

    localparam int SLOTS      = 32;
    localparam int COUNT_BITS = 16;

    // sem_id is five bits wide, so only the slots it can name are kept
    localparam int ID_BITS    = 5;
    localparam int ID_LIMIT   = 1 << ID_BITS;
    localparam int USED_SLOTS = (SLOTS < ID_LIMIT) ? SLOTS : ID_LIMIT;
    localparam int IDX_W      = (USED_SLOTS > 2) ? $clog2(USED_SLOTS) : 1;

    localparam int INIT_BITS  = 16;
    localparam int CMP_W      = (COUNT_BITS > INIT_BITS) ? COUNT_BITS : INIT_BITS;

    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 16;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_WAIT    = 2'd2,
        CMD_SIGNAL  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BAD_ID = 2'd1,
        ST_FULL   = 2'd2,
        ST_SAT    = 2'd3
    } status_t;

    typedef struct packed {
        logic                          wake_waiter;
        logic                          block_caller;
        logic [ID_BITS-1:0]            new_id;
        status_t                       status;
    } result_t;

endpackage

/* hw/rtl/counting_semaphore_table_top.sv */
// Counting semaphore table: create, destroy, wait and signal on up to 31 slots.
// A request accepted into the input register has its result registered on m_tdata
// once it advances. Throughput: one request per cycle unless m_tready stalls;
// the free-slot priority encoder and one count increment or decrement sit
// between the input and result registers.
// Reset (aresetn low, synchronous) frees every slot and empties both stages.
module counting_semaphore_table_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd [1:0], sem_id [6:2], init_count [22:7], zero [23]
    input  logic [cst_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status [1:0], new_id [6:2], block_caller [7], wake_waiter [8], zero [15:9]
    output logic [cst_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int CB = cst_pkg::COUNT_BITS;
    localparam int IW = cst_pkg::IDX_W;
    localparam int NS = cst_pkg::USED_SLOTS;

    localparam logic signed [CB-1:0] CNT_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] CNT_MIN = {1'b1, {(CB-1){1'b0}}};

    // input register
    logic                              in_valid_reg;
    cst_pkg::cmd_t                     cmd_reg;
    logic [cst_pkg::ID_BITS-1:0]       sem_id_reg;
    logic signed [cst_pkg::INIT_BITS-1:0] init_reg;

    // result register
    logic                              out_valid_reg;
    cst_pkg::result_t                  res_reg;
    cst_pkg::result_t                  res_next;

    // table state
    logic [NS-1:0]                     slot_valid_reg;
    logic signed [CB-1:0]              count_reg [NS];

    logic                              advance;
    logic                              id_ok;
    logic [IW-1:0]                     id_idx;
    logic                              free_found;
    logic [IW-1:0]                     free_idx;
    logic signed [CB-1:0]              cnt_cur;
    logic signed [CB-1:0]              cnt_new;
    logic signed [cst_pkg::CMP_W-1:0]  init_ext;
    logic                              cnt_we;
    logic [IW-1:0]                     cnt_idx;
    logic                              valid_set;
    logic                              valid_clr;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = cst_pkg::M_DATA_W'(res_reg);

    assign id_idx   = sem_id_reg[IW-1:0];
    assign id_ok    = (sem_id_reg != '0)
                   && ({1'b0, sem_id_reg} < (cst_pkg::ID_BITS + 1)'(NS))
                   && slot_valid_reg[id_idx];
    assign cnt_cur  = count_reg[id_idx];
    assign init_ext = cst_pkg::CMP_W'(init_reg);

    // lowest free slot from 1 upward; slot 0 is reserved
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NS - 1; i >= 1; i--) begin
            if (!slot_valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    always_comb begin
        res_next   = '0;
        res_next.status = cst_pkg::ST_OK;
        cnt_new    = cnt_cur;
        cnt_we     = 1'b0;
        cnt_idx    = id_idx;
        valid_set  = 1'b0;
        valid_clr  = 1'b0;
        if (cmd_reg == cst_pkg::CMD_CREATE) begin
            if (!free_found) begin
                res_next.status = cst_pkg::ST_FULL;
            end else begin
                cnt_idx   = free_idx;
                cnt_we    = 1'b1;
                valid_set = 1'b1;
                res_next.new_id = cst_pkg::ID_BITS'(free_idx);
                // clamp the initial count into the count range
                if (init_ext > cst_pkg::CMP_W'(CNT_MAX)) begin
                    cnt_new = CNT_MAX;
                    res_next.status = cst_pkg::ST_SAT;
                end else if (init_ext < cst_pkg::CMP_W'(CNT_MIN)) begin
                    cnt_new = CNT_MIN;
                    res_next.status = cst_pkg::ST_SAT;
                end else begin
                    cnt_new = CB'(init_ext);
                end
            end
        end else if (!id_ok) begin
            res_next.status = cst_pkg::ST_BAD_ID;
        end else begin
            case (cmd_reg)
                cst_pkg::CMD_DESTROY: begin
                    valid_clr = 1'b1;
                end
                cst_pkg::CMD_WAIT: begin
                    cnt_we = 1'b1;
                    if (cnt_cur == CNT_MIN) begin
                        res_next.status = cst_pkg::ST_SAT;
                    end else begin
                        cnt_new = cnt_cur - CB'(1);
                    end
                    res_next.block_caller = cnt_new[CB-1];
                end
                cst_pkg::CMD_SIGNAL: begin
                    cnt_we = 1'b1;
                    if (cnt_cur == CNT_MAX) begin
                        res_next.status = cst_pkg::ST_SAT;
                    end else begin
                        cnt_new = cnt_cur + CB'(1);
                    end
                    res_next.wake_waiter = cnt_new[CB-1] || (cnt_new == '0);
                end
                default: begin
                    res_next.status = cst_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance && valid_set) begin
                slot_valid_reg[cnt_idx] <= 1'b1;
            end
            if (advance && valid_clr) begin
                slot_valid_reg[id_idx] <= 1'b0;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd_reg    <= cst_pkg::cmd_t'(s_tdata[1:0]);
            sem_id_reg <= s_tdata[6:2];
            init_reg   <= s_tdata[22:7];
        end
        if (advance) begin
            res_reg <= res_next;
        end
        if (advance && cnt_we) begin
            count_reg[cnt_idx] <= cnt_new;
        end
    end

endmodule
